// ===== hw/rtl/pl_pkg.sv =====
// shared constants and codes for the positional list engine
package pl_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 16;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int OCNT_W   = 7;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_PAST  = 2'd3;

endpackage

// ===== hw/rtl/positional_list_engine.sv =====
// top level of the positional list engine: sequencer around the entry ram
//
// Ordered list of up to CAPACITY signed 32-bit entries, addressed by position.
// Input channel s_*: kind (insert, delete, read), position and value; one item
// at a time is taken, s_ready is high while the sequencer is idle.
// Result channel m_*: one result per item with read_value, status and the
// entry count after the operation, held in an output register.
// Steps per item, n entries held, p the clamped position:
//   insert: moves entries n-1 down to p up by one place (each moved entry is
//           one ram read and one write), then writes the new value at p
//   delete: moves entries p+1 to n-1 down by one place, one read and one write each
//   read:   one registered ram read; refused, empty, past-end and unused-kind
//           cases leave the ram untouched
// Entries move one at a time through the single write port of the entry ram.
// The output register lets the next item be taken while a result waits; a
// finished operation waits in place only if that register is still full.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; ram contents are not cleared and never read before being written.
module positional_list_engine
    import pl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [KIND_W-1:0]        s_kind,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_read_value,
    output logic [STAT_W-1:0]        m_status,
    output logic [OCNT_W-1:0]        m_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_RD_WAIT,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [DATA_W-1:0]   res_value_reg, res_value_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_value_reg, m_value_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;
    logic [OCNT_W-1:0]   m_count_reg, m_count_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [DATA_W-1:0]   rd_data;

    logic                accept;
    logic [CMP_W-1:0]    pos_cmp;
    logic [CMP_W-1:0]    count_cmp;
    logic [CNT_W-1:0]    last_idx;
    logic [ADDR_W-1:0]   del_pos;

    pl_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign accept        = s_valid && s_ready;
    assign pos_cmp       = CMP_W'(s_position);
    assign count_cmp     = CMP_W'(count_reg);
    assign last_idx      = count_reg - CNT_W'(1);
    assign del_pos       = (pos_cmp > CMP_W'(last_idx)) ? last_idx[ADDR_W-1:0]
                                                        : s_position[ADDR_W-1:0];

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_value_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

    // ram port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = s_position[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE: begin
                rd_en = accept && (s_kind == KIND_READ);
            end
            S_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_reg - ADDR_W'(1);
            end
            S_INS_WR: begin
                wr_en = 1'b1;
            end
            S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = val_reg;
            end
            S_DEL_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_reg + ADDR_W'(1);
            end
            S_DEL_WR: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_value_next  = '0;
                    res_status_next = ST_DONE;
                    val_next        = s_value;
                    state_next      = S_DONE;
                    case (s_kind)
                        KIND_INSERT: begin
                            if (count_reg >= CNT_W'(CAPACITY)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                ptr_next = count_reg[ADDR_W-1:0];
                                if (pos_cmp >= count_cmp) begin
                                    // append at the end, nothing to move
                                    pos_next   = count_reg[ADDR_W-1:0];
                                    state_next = S_INS_PUT;
                                end else begin
                                    pos_next   = s_position[ADDR_W-1:0];
                                    state_next = S_INS_RD;
                                end
                            end
                        end
                        KIND_DELETE: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                ptr_next = del_pos;
                                if ((CNT_W'(del_pos) + CNT_W'(1)) < count_reg) begin
                                    state_next = S_DEL_RD;
                                end else begin
                                    count_next = last_idx;
                                end
                            end
                        end
                        KIND_READ: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                            end else if (pos_cmp >= count_cmp) begin
                                res_status_next = ST_PAST;
                            end else begin
                                state_next = S_RD_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                ptr_next = ptr_reg - ADDR_W'(1);
                if ((ptr_reg - ADDR_W'(1)) == pos_reg) begin
                    state_next = S_INS_PUT;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_PUT: begin
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DEL_RD: begin
                state_next = S_DEL_WR;
            end
            S_DEL_WR: begin
                ptr_next = ptr_reg + ADDR_W'(1);
                // stop once the moved entry was the last one
                if ((CNT_W'(ptr_reg) + CNT_W'(2)) < count_reg) begin
                    state_next = S_DEL_RD;
                end else begin
                    count_next = last_idx;
                    state_next = S_DONE;
                end
            end
            S_RD_WAIT: begin
                res_value_next = rd_data;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = OCNT_W'(count_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

endmodule

// ===== hw/rtl/pl_ram.sv =====
// simple dual-port ram, one write port and one registered read port
module pl_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
